[hw/rtl/first_fit_heap_allocator_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the first-fit heap allocator
// Short forms for clocked implication checks with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication.
`define FFHA_ASSERT_IMP(label, clk_sig, rst_n_sig, ante, cons, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) \
		(ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define FFHA_ASSERT_NXT(label, clk_sig, rst_n_sig, ante, cons, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) \
		(ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/ffha_pkg.sv]
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package ffha_pkg;

	localparam int HEAP_WORDS  = 2048;
	localparam int ADDR_W      = 11;
	localparam int DATA_W      = 16;
	localparam int SIZE_W      = 12;
	localparam int HDR_WORDS   = 2;
	localparam int SIZE_MAX    = 4095;

	typedef enum logic [1:0] {
		REQ_READ  = 2'd0,
		REQ_WRITE = 2'd1,
		REQ_ALLOC = 2'd2,
		REQ_FREE  = 2'd3
	} req_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NOFIT = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef enum logic [2:0] {
		RES_OK,
		RES_READ,
		RES_ALLOC,
		RES_NOFIT,
		RES_FULL
	} res_sel_t;

	typedef struct packed {
		logic     clear_step;
		logic     req_load;
		logic     scan_clear;
		logic     seg_read;
		logic     seg_update;
		logic     seg_append;
		logic     ram_wr_req;
		logic     hdr0_wr;
		logic     hdr1_wr;
		logic     ram_rd_req;
		logic     ram_rd_free;
		logic     out_load;
		res_sel_t res_sel;
	} ffha_cmd_t;

	typedef struct packed {
		req_t req_type;
		logic table_full;
		logic scan_hit;
		logic scan_end;
		logic clr_last;
		logic out_free;
	} ffha_sts_t;

endpackage

[hw/rtl/ffha_ctrl.sv]
// ----------------------------------------------------------------------------
// ffha_ctrl
// Request sequencer: heap clearing after reset, dispatch and result handoff.
// ----------------------------------------------------------------------------
module ffha_ctrl
	import ffha_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  ffha_sts_t sts,
	output ffha_cmd_t cmd
);

	typedef enum logic [3:0] {
		CLEAR,
		IDLE,
		EXEC,
		RD_WAIT,
		SCAN,
		HDR0,
		HDR1,
		FREE_WAIT,
		RESP
	} state_t;

	state_t   state_q;
	res_sel_t res_sel_q;

	assign s_tready = (state_q == IDLE);

	always_comb begin
		cmd             = '0;
		cmd.res_sel     = res_sel_q;
		cmd.clear_step  = (state_q == CLEAR);
		cmd.req_load    = (state_q == IDLE) && s_tvalid;
		cmd.scan_clear  = (state_q == EXEC) && (sts.req_type == REQ_ALLOC);
		cmd.ram_wr_req  = (state_q == EXEC) && (sts.req_type == REQ_WRITE);
		cmd.ram_rd_req  = (state_q == EXEC) && (sts.req_type == REQ_READ);
		cmd.ram_rd_free = (state_q == EXEC) && (sts.req_type == REQ_FREE) && !sts.table_full;
		cmd.seg_read    = (state_q == SCAN) && !sts.scan_hit && !sts.scan_end;
		cmd.seg_update  = (state_q == HDR0);
		cmd.hdr0_wr     = (state_q == HDR0);
		cmd.hdr1_wr     = (state_q == HDR1);
		cmd.seg_append  = (state_q == FREE_WAIT);
		cmd.out_load    = (state_q == RESP) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= CLEAR;
			res_sel_q <= RES_OK;
		end else begin
			case (state_q)
				CLEAR: begin
					if (sts.clr_last) state_q <= IDLE;
				end
				IDLE: begin
					if (s_tvalid) state_q <= EXEC;
				end
				EXEC: begin
					case (sts.req_type)
						REQ_READ: begin
							state_q <= RD_WAIT;
						end
						REQ_WRITE: begin
							res_sel_q <= RES_OK;
							state_q   <= RESP;
						end
						REQ_ALLOC: begin
							state_q <= SCAN;
						end
						REQ_FREE: begin
							if (sts.table_full) begin
								res_sel_q <= RES_FULL;
								state_q   <= RESP;
							end else begin
								state_q <= FREE_WAIT;
							end
						end
						default: state_q <= IDLE;
					endcase
				end
				RD_WAIT: begin
					res_sel_q <= RES_READ;
					state_q   <= RESP;
				end
				SCAN: begin
					if (sts.scan_hit) begin
						state_q <= HDR0;
					end else if (sts.scan_end) begin
						res_sel_q <= RES_NOFIT;
						state_q   <= RESP;
					end
				end
				HDR0: begin
					state_q <= HDR1;
				end
				HDR1: begin
					res_sel_q <= RES_ALLOC;
					state_q   <= RESP;
				end
				FREE_WAIT: begin
					res_sel_q <= RES_OK;
					state_q   <= RESP;
				end
				RESP: begin
					if (sts.out_free) state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

[hw/rtl/ffha_datapath.sv]
// ----------------------------------------------------------------------------
// ffha_datapath
// Heap RAM, free-segment table, scan compare and the result register.
// ----------------------------------------------------------------------------
module ffha_datapath
	import ffha_pkg::*;
#(
	parameter int MAX_SEGMENTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ffha_cmd_t   cmd,
	output ffha_sts_t   sts,
	input  logic [1:0]  s_tuser,
	input  logic [39:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,
	output logic [1:0]  m_tuser
);

	localparam int SEG_IDX_W = $clog2(MAX_SEGMENTS);
	localparam int CNT_W     = $clog2(MAX_SEGMENTS + 1);

	logic [DATA_W-1:0] heap_mem [HEAP_WORDS];
	logic [ADDR_W-1:0] seg_start_mem [MAX_SEGMENTS];
	logic [SIZE_W-1:0] seg_size_mem [MAX_SEGMENTS];

	req_t              req_type_q;
	logic [ADDR_W-1:0] req_addr_q;
	logic [DATA_W-1:0] req_wval_q;
	logic [ADDR_W-1:0] req_size_q;

	logic [ADDR_W-1:0] clr_addr_q;
	logic [DATA_W-1:0] ram_rd_q;

	logic [CNT_W-1:0]     seg_cnt_q;
	logic                 seg0_fresh_q;
	logic [CNT_W-1:0]     scan_idx_q;
	logic                 cand_valid_q;
	logic                 cand_fresh_q;
	logic [SEG_IDX_W-1:0] cand_idx_q;
	logic [ADDR_W-1:0]    cand_start_raw_q;
	logic [SIZE_W-1:0]    cand_size_raw_q;
	logic [ADDR_W-1:0]    base_q;

	logic                 out_valid_q;
	logic [DATA_W-1:0]    out_rdata_q;
	logic [ADDR_W-1:0]    out_aaddr_q;
	logic [1:0]           out_status_q;

	logic [ADDR_W-1:0]    cand_start;
	logic [SIZE_W-1:0]    cand_size;
	logic [SIZE_W-1:0]    need;
	logic [SIZE_W-1:0]    new_size;
	logic [SIZE_W:0]      base_sum;
	logic [ADDR_W-1:0]    alloc_base;
	logic [ADDR_W-1:0]    free_base;
	logic [DATA_W:0]      free_sum;
	logic [SIZE_W-1:0]    free_size;

	logic                 ram_we;
	logic [ADDR_W-1:0]    ram_waddr;
	logic [DATA_W-1:0]    ram_wdata;
	logic [ADDR_W-1:0]    ram_raddr;

	logic                 seg_we;
	logic [SEG_IDX_W-1:0] seg_waddr;
	logic [ADDR_W-1:0]    seg_wstart;
	logic [SIZE_W-1:0]    seg_wsize;

	// Entry 0 reads as the whole heap until the first allocation rewrites it.
	assign cand_start = cand_fresh_q ? '0 : cand_start_raw_q;
	assign cand_size  = cand_fresh_q ? SIZE_W'(HEAP_WORDS) : cand_size_raw_q;
	assign need       = SIZE_W'(req_size_q) + SIZE_W'(HDR_WORDS);
	assign new_size   = cand_size - need;
	assign base_sum   = (SIZE_W + 1)'(cand_start) + (SIZE_W + 1)'(new_size);
	assign alloc_base = base_sum[ADDR_W-1:0];
	assign free_base  = req_addr_q - ADDR_W'(HDR_WORDS);
	assign free_sum   = (DATA_W + 1)'(ram_rd_q) + (DATA_W + 1)'(HDR_WORDS);
	assign free_size  = (free_sum > (DATA_W + 1)'(SIZE_MAX)) ? SIZE_W'(SIZE_MAX)
		: free_sum[SIZE_W-1:0];

	assign sts.req_type   = req_type_q;
	assign sts.table_full = (seg_cnt_q >= CNT_W'(MAX_SEGMENTS));
	assign sts.scan_hit   = cand_valid_q && (cand_size > need);
	assign sts.scan_end   = (scan_idx_q == seg_cnt_q);
	assign sts.clr_last   = (clr_addr_q == ADDR_W'(HEAP_WORDS - 1));
	assign sts.out_free   = !out_valid_q || m_tready;

	always_comb begin
		ram_we    = cmd.clear_step || cmd.ram_wr_req || cmd.hdr0_wr || cmd.hdr1_wr;
		ram_waddr = clr_addr_q;
		ram_wdata = '0;
		if (cmd.ram_wr_req) begin
			ram_waddr = req_addr_q;
			ram_wdata = req_wval_q;
		end else if (cmd.hdr0_wr) begin
			ram_waddr = alloc_base;
		end else if (cmd.hdr1_wr) begin
			ram_waddr = base_q + ADDR_W'(1);
			ram_wdata = DATA_W'(req_size_q);
		end
		ram_raddr = cmd.ram_rd_free ? (free_base + ADDR_W'(1)) : req_addr_q;
	end

	always_comb begin
		seg_we     = cmd.seg_update || cmd.seg_append;
		seg_waddr  = cand_idx_q;
		seg_wstart = cand_start;
		seg_wsize  = new_size;
		if (cmd.seg_append) begin
			seg_waddr  = seg_cnt_q[SEG_IDX_W-1:0];
			seg_wstart = free_base;
			seg_wsize  = free_size;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) heap_mem[ram_waddr] <= ram_wdata;
		if (cmd.ram_rd_req || cmd.ram_rd_free) ram_rd_q <= heap_mem[ram_raddr];
	end

	always_ff @(posedge clk) begin
		if (seg_we) begin
			seg_start_mem[seg_waddr] <= seg_wstart;
			seg_size_mem[seg_waddr]  <= seg_wsize;
		end
		if (cmd.seg_read) begin
			cand_start_raw_q <= seg_start_mem[scan_idx_q[SEG_IDX_W-1:0]];
			cand_size_raw_q  <= seg_size_mem[scan_idx_q[SEG_IDX_W-1:0]];
			cand_idx_q       <= scan_idx_q[SEG_IDX_W-1:0];
			cand_fresh_q     <= seg0_fresh_q && (scan_idx_q == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.req_load) begin
			req_type_q <= req_t'(s_tuser);
			req_addr_q <= s_tdata[10:0];
			req_wval_q <= s_tdata[26:11];
			req_size_q <= s_tdata[37:27];
		end
		if (cmd.seg_update) base_q <= alloc_base;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q   <= '0;
			seg_cnt_q    <= CNT_W'(1);
			seg0_fresh_q <= 1'b1;
			scan_idx_q   <= '0;
			cand_valid_q <= 1'b0;
		end else begin
			if (cmd.clear_step) clr_addr_q <= clr_addr_q + ADDR_W'(1);
			if (cmd.seg_append) seg_cnt_q <= seg_cnt_q + CNT_W'(1);
			if (cmd.seg_update && (cand_idx_q == '0)) seg0_fresh_q <= 1'b0;
			if (cmd.scan_clear) begin
				scan_idx_q <= '0;
			end else if (cmd.seg_read) begin
				scan_idx_q <= scan_idx_q + CNT_W'(1);
			end
			cand_valid_q <= cmd.seg_read;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_rdata_q  <= (cmd.res_sel == RES_READ) ? ram_rd_q : '0;
			out_aaddr_q  <= (cmd.res_sel == RES_ALLOC) ? (base_q + ADDR_W'(HDR_WORDS)) : '0;
			case (cmd.res_sel)
				RES_NOFIT: out_status_q <= ST_NOFIT;
				RES_FULL:  out_status_q <= ST_FULL;
				default:   out_status_q <= ST_OK;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, out_aaddr_q, out_rdata_q};
	assign m_tuser  = out_status_q;

endmodule

[hw/rtl/first_fit_heap_allocator.sv]
// ----------------------------------------------------------------------------
// first_fit_heap_allocator: first-fit heap manager over a 2048-word RAM.
// Reset clears the RAM one word a cycle with s_tready low. An allocation takes
// longer the more table entries it scans. One request at a time; the next is
// accepted the cycle after the result register loads.
// ----------------------------------------------------------------------------
`include "first_fit_heap_allocator_defines.svh"

module first_fit_heap_allocator
	import ffha_pkg::*;
#(
	parameter int MAX_SEGMENTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// address [10:0], write_value [26:11], alloc_size [37:27], zero [39:38]
	input  logic [39:0] s_tdata,
	// req_type [1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// read_data [15:0], alloc_address [26:16], zero [31:27]
	output logic [31:0] m_tdata,
	// status [1:0]
	output logic [1:0]  m_tuser
);

	ffha_cmd_t cmd;
	ffha_sts_t sts;

	ffha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ffha_datapath #(
		.MAX_SEGMENTS (MAX_SEGMENTS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	`FFHA_ASSERT_IMP(a_no_accept_in_clear, clk, arst_n, cmd.clear_step, !s_tready, "transfer accepted during heap clear")
	`FFHA_ASSERT_IMP(a_one_ram_writer, clk, arst_n, 1'b1, $onehot0({cmd.clear_step, cmd.ram_wr_req, cmd.hdr0_wr, cmd.hdr1_wr}), "conflicting heap RAM writes")
	`FFHA_ASSERT_IMP(a_load_when_free, clk, arst_n, cmd.out_load, sts.out_free, "result overwrites a pending transfer")
	`FFHA_ASSERT_NXT(a_fail_no_address, clk, arst_n, cmd.out_load && (cmd.res_sel == RES_NOFIT || cmd.res_sel == RES_FULL), m_tdata[26:16] == '0, "failed request carries an address")

endmodule
